### rtl/core/dcs_pkg.sv
// package with shared constants and types of the digraph substituter
`timescale 1ns / 1ps
package dcs_pkg;

  localparam int SEARCH_DEPTH  = 64;
  localparam int REPLACE_DEPTH = 32;
  localparam int SADDR_W       = $clog2(SEARCH_DEPTH);
  localparam int RADDR_W       = $clog2(REPLACE_DEPTH);
  localparam int SLEN_W        = $clog2(SEARCH_DEPTH + 1);
  localparam int RLEN_W        = $clog2(REPLACE_DEPTH + 1);
  localparam int CHAR_W        = 8;
  localparam int IDX_W         = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int ENTRY_W       = CHAR_W + 1;

  localparam logic [1:0] OP_SEARCH  = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_TEXT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_PASS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_BYTES = 2'd2;

  // entry: char in the low bits, last mark on top
  typedef struct packed {
    logic [1:0]         cnt;
    logic [ENTRY_W-1:0] d1;
    logic [ENTRY_W-1:0] d0;
  } dcs_push_t;

endpackage

### rtl/core/dcs_ram.sv
// generic simple dual-port ram with registered read data
`timescale 1ns / 1ps
module dcs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/dcs_outq.sv
// four-entry output queue taking up to two entries per cycle
`timescale 1ns / 1ps
module dcs_outq
  import dcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dcs_push_t         push,
  output logic              room2,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,
  output logic              out_tlast
);

  logic [ENTRY_W-1:0] q_r [4];
  logic [1:0]         wptr_r, wptr_nxt;
  logic [1:0]         rptr_r, rptr_nxt;
  logic [2:0]         count_r, count_nxt;
  logic               pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (count_r != 3'd0);
  assign out_tdata  = q_r[rptr_r][CHAR_W-1:0];
  assign out_tlast  = q_r[rptr_r][CHAR_W];
  assign room2      = (count_r <= 3'd2);

  always_comb begin
    wptr_nxt  = wptr_r + push.cnt;
    rptr_nxt  = rptr_r + {1'b0, pop};
    count_nxt = count_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wptr_r] <= push.d0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wptr_r + 2'd1] <= push.d1;
    end
  end

endmodule

### rtl/core/digraph_to_char_substituter_unit.sv
// top level: table loading, pair search sequencer and output queue
`timescale 1ns / 1ps
// Items are taken one at a time. A table write (tuser 0 search byte, 1 replacement
// byte) or an unused code needs no search. A text character with a character held
// scans the search memory one byte per cycle from offset 0, ending early at the
// first occurrence of the pair, and on a match reads the replacement memory as well;
// the scan uses the single read port of the search memory. With no character
// held, after a single-pass replacement, or with the tables too short, a character
// needs no search. Results leave through a four-entry queue, so the next item is
// taken while up to two results still wait. Unwritten table entries read as
// anything.
module digraph_to_char_substituter_unit
  import dcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // table_index[5:0], byte_value[13:6], zero pad
  input  logic [1:0]            in_tuser,   // op[1:0]
  input  logic                  in_tlast,   // end_of_text
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // out_char[7:0]
  output logic                  out_tlast,  // out_last
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_REP  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               multi_r;
  logic [SLEN_W-1:0]  slen_r;
  logic [RLEN_W-1:0]  rlen_r;
  logic [CHAR_W-1:0]  held_r, held_nxt;
  logic               have_r, have_nxt;
  logic               skip_r, skip_nxt;
  logic [CHAR_W-1:0]  val_r, val_nxt;
  logic               last_r, last_nxt;
  logic [SLEN_W-1:0]  ra_r, ra_nxt;
  logic [SADDR_W-1:0] da_r, da_nxt;
  logic               dv_r, dv_nxt;
  logic [CHAR_W-1:0]  prev_r, prev_nxt;

  logic               acc;
  logic [1:0]         op;
  logic [IDX_W-1:0]   tidx;
  logic [CHAR_W-1:0]  tval;
  logic               room2;
  dcs_push_t          push;

  logic               s_re;
  logic [CHAR_W-1:0]  s_rdata;
  logic               r_re;
  logic [RADDR_W-1:0] r_raddr;
  logic [CHAR_W-1:0]  r_rdata;
  logic [SADDR_W-1:0] off;
  logic [RADDR_W-1:0] half;

  assign op        = in_tuser;
  assign tidx      = in_tdata[IDX_W-1:0];
  assign tval      = in_tdata[IDX_W +: CHAR_W];
  assign in_tready = (state_r == S_IDLE) && room2;
  assign acc       = in_tvalid && in_tready;
  assign off       = da_r - SADDR_W'(1);
  assign half      = off[SADDR_W-1:1];

  dcs_ram #(.DEPTH(SEARCH_DEPTH), .WIDTH(CHAR_W)) u_search (
    .clk   (clk),
    .we    (acc && (op == OP_SEARCH)),
    .waddr (tidx[SADDR_W-1:0]),
    .wdata (tval),
    .re    (s_re),
    .raddr (ra_r[SADDR_W-1:0]),
    .rdata (s_rdata)
  );

  dcs_ram #(.DEPTH(REPLACE_DEPTH), .WIDTH(CHAR_W)) u_replace (
    .clk   (clk),
    .we    (acc && (op == OP_REPLACE) && (tidx < IDX_W'(REPLACE_DEPTH))),
    .waddr (tidx[RADDR_W-1:0]),
    .wdata (tval),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  dcs_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room2      (room2),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    have_nxt  = have_r;
    skip_nxt  = skip_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    ra_nxt    = ra_r;
    da_nxt    = da_r;
    dv_nxt    = 1'b0;
    prev_nxt  = prev_r;
    s_re      = 1'b0;
    r_re      = 1'b0;
    r_raddr   = half;
    push      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc && (op == OP_TEXT)) begin
          val_nxt  = tval;
          last_nxt = in_tlast;
          if (!have_r) begin
            held_nxt = tval;
            have_nxt = 1'b1;
            skip_nxt = 1'b0;
            if (in_tlast) begin
              push.cnt = 2'd1;
              push.d0  = {1'b1, tval};
              have_nxt = 1'b0;
            end
          end else if (skip_r || (slen_r < SLEN_W'(2)) || (rlen_r == '0)) begin
            push.d0  = {1'b0, held_r};
            push.d1  = {1'b1, tval};
            push.cnt = in_tlast ? 2'd2 : 2'd1;
            held_nxt = tval;
            skip_nxt = 1'b0;
            if (in_tlast) begin
              have_nxt = 1'b0;
            end
          end else begin
            ra_nxt    = '0;
            prev_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ra_r < slen_r) begin
          s_re   = 1'b1;
          dv_nxt = 1'b1;
          da_nxt = ra_r[SADDR_W-1:0];
          ra_nxt = ra_r + SLEN_W'(1);
        end
        if (dv_r) begin
          prev_nxt = s_rdata;
          if ((da_r != '0) && (prev_r == held_r) && (s_rdata == val_r) && !da_r[0]) begin
            dv_nxt = 1'b0;
            // first occurrence at odd offset: no match
            push.d0  = {1'b0, held_r};
            push.d1  = {1'b1, val_r};
            push.cnt = last_r ? 2'd2 : 2'd1;
            held_nxt = val_r;
            skip_nxt = 1'b0;
            if (last_r) begin
              have_nxt = 1'b0;
            end
            state_nxt = S_IDLE;
          end else if ((da_r != '0) && (prev_r == held_r) && (s_rdata == val_r)) begin
            dv_nxt = 1'b0;
            r_re   = 1'b1;
            if ({1'b0, half} >= rlen_r) begin
              r_raddr = RADDR_W'(rlen_r - RLEN_W'(1));
            end
            state_nxt = S_REP;
          end else if ({1'b0, da_r} == (slen_r - SLEN_W'(1))) begin
            dv_nxt   = 1'b0;
            push.d0  = {1'b0, held_r};
            push.d1  = {1'b1, val_r};
            push.cnt = last_r ? 2'd2 : 2'd1;
            held_nxt = val_r;
            skip_nxt = 1'b0;
            if (last_r) begin
              have_nxt = 1'b0;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      S_REP: begin
        held_nxt = r_rdata;
        skip_nxt = !multi_r;
        if (last_r) begin
          push.cnt = 2'd1;
          push.d0  = {1'b1, r_rdata};
          have_nxt = 1'b0;
          skip_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      have_r  <= 1'b0;
      skip_r  <= 1'b0;
      dv_r    <= 1'b0;
      multi_r <= 1'b0;
      slen_r  <= '0;
      rlen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      have_r  <= have_nxt;
      skip_r  <= skip_nxt;
      dv_r    <= dv_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MULTI_PASS: multi_r <= cfg_wdata[0];
          CFG_SEARCH_BYTES: begin
            slen_r <= (cfg_wdata > CFG_DATA_W'(SEARCH_DEPTH)) ? SLEN_W'(SEARCH_DEPTH)
                                                             : SLEN_W'(cfg_wdata);
          end
          CFG_REPLACE_BYTES: begin
            rlen_r <= (cfg_wdata[RLEN_W-1:0] > RLEN_W'(REPLACE_DEPTH))
                      ? RLEN_W'(REPLACE_DEPTH) : cfg_wdata[RLEN_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
    ra_r   <= ra_nxt;
    da_r   <= da_nxt;
    prev_r <= prev_nxt;
  end

  a_rep_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REP) |-> $past(state_r == S_SCAN))
    else $error("replacement read without a preceding scan");

  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (have_r && !skip_r))
    else $error("search running without a held character");

  a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == S_SCAN))
    else $error("search data outside a scan");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("transaction accepted while a search runs");

endmodule
